// ----- hdl/pair_distance_histogram_unit_assert.svh -----
// assertion macros for the pair distance histogram unit
// used by the top level only; expects a clock named clk and a reset named rst
`ifndef PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PDH_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pdh assertion failed");
`define PDH_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pdh assertion failed");
`else
`define PDH_ASSERT(label, cond)
`define PDH_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// ----- hdl/pdh_pkg.sv -----
// shared constants, payload types and control structs of the pair distance histogram unit
// no dependencies; used by pdh_ctrl, pdh_datapath and the top level
package pdh_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PT_CW      = PT_AW + 1;
  localparam int NUM_BINS   = 64;
  localparam int BIN_AW     = 6;
  localparam int NB_W       = 7;
  localparam int QUO_W      = NB_W + 1;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int COORD_W    = 32;
  localparam int COUNT_W    = 25;
  localparam int WIDTH_W    = 31;
  localparam int SMALL_W    = 16;
  localparam int DIV_W      = WIDTH_W + QUO_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST = 31'd524;
  localparam logic [SMALL_W-1:0] SMALL_RST     = 16'd7;
  localparam logic [NB_W-1:0]    BINS_RST      = 7'd50;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS      = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] coordinate;
  } req_t;

  typedef struct packed {
    logic [BIN_AW-1:0]  bin_index;
    logic [COUNT_W-1:0] pair_count;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic               mode;
    logic [WIDTH_W-1:0] bin_width;
    logic [SMALL_W-1:0] small_distance;
    logic [NB_W-1:0]    bins_in_use;
  } cfg_t;

  typedef struct packed {
    logic                      load_a;
    logic                      load_b;
    logic                      clear_sets;
    logic signed [COORD_W-1:0] point;
    logic                      rd_pts;
    logic [PT_AW-1:0]          addr_i;
    logic [PT_AW-1:0]          addr_j;
    logic                      calc_dist;
    logic                      div_step;
    logic [STEP_W-1:0]         step;
    logic                      hist_clr;
    logic                      hist_sample;
    logic                      hist_inc;
    logic                      emit_sel;
    logic [BIN_AW-1:0]         bin_addr;
    logic                      out_load;
    logic                      out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [PT_CW-1:0] count_a;
    logic [PT_CW-1:0] count_b;
  } dp_status_t;

  function automatic logic [NB_W-1:0] eff_bins(input logic [NB_W-1:0] b);
    if (int'(b) > NUM_BINS) begin
      return NB_W'(NUM_BINS);
    end
    return b;
  endfunction

  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    return (w == '0) ? WIDTH_W'(1) : w;
  endfunction

endpackage

// ----- hdl/pdh_ctrl.sv -----
// controller of the pair distance histogram unit: handshakes, pair loop, clear and emit sequencing
// depends on pdh_pkg; drives the datapath through pdh_pkg::dp_cmd_t
module pdh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  pdh_pkg::req_t       req,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  pdh_pkg::cfg_t       cfg,
  input  pdh_pkg::dp_status_t status,
  output pdh_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_PAIR_NEXT,
    S_PAIR_DIST,
    S_PAIR_DIV,
    S_HIST_READ,
    S_HIST_WRITE,
    S_EMIT_READ,
    S_EMIT_LOAD,
    S_EMIT_HOLD
  } state_t;

  state_t                      state;
  logic [pdh_pkg::PT_CW-1:0]   i;
  logic [pdh_pkg::PT_CW-1:0]   j;
  logic [pdh_pkg::NB_W-1:0]    bin;
  logic [pdh_pkg::STEP_W-1:0]  step;

  logic                        accept;
  logic [pdh_pkg::NB_W-1:0]    nb;
  logic [pdh_pkg::PT_CW-1:0]   jlim;
  logic                        row_done;
  logic                        all_done;
  logic                        last_bin;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign nb        = pdh_pkg::eff_bins(cfg.bins_in_use);
  // auto mode walks j below i, cross mode walks all of set b
  assign jlim      = cfg.mode ? status.count_b : i;
  assign row_done  = (j >= jlim);
  assign all_done  = (i >= status.count_a);
  assign last_bin  = ((bin + pdh_pkg::NB_W'(1)) == nb);

  always_comb begin
    cmd             = '0;
    cmd.point       = req.coordinate;
    cmd.addr_i      = i[pdh_pkg::PT_AW-1:0];
    cmd.addr_j      = j[pdh_pkg::PT_AW-1:0];
    cmd.step        = step;
    cmd.bin_addr    = bin[pdh_pkg::BIN_AW-1:0];
    cmd.out_last    = last_bin;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.kind)
            pdh_pkg::KIND_LOAD_A: cmd.load_a     = 1'b1;
            pdh_pkg::KIND_LOAD_B: cmd.load_b     = 1'b1;
            pdh_pkg::KIND_CLEAR:  cmd.clear_sets = 1'b1;
            default: ;
          endcase
        end
      end
      S_CLEAR:      cmd.hist_clr    = 1'b1;
      S_PAIR_NEXT:  cmd.rd_pts      = !all_done && !row_done;
      S_PAIR_DIST:  cmd.calc_dist   = 1'b1;
      S_PAIR_DIV:   cmd.div_step    = 1'b1;
      S_HIST_READ:  cmd.hist_sample = 1'b1;
      S_HIST_WRITE: cmd.hist_inc    = 1'b1;
      S_EMIT_READ:  cmd.emit_sel    = 1'b1;
      S_EMIT_LOAD:  cmd.out_load    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      bin       <= '0;
      step      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && req.kind == pdh_pkg::KIND_START) begin
            bin   <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (bin == pdh_pkg::NB_W'(pdh_pkg::NUM_BINS - 1)) begin
            bin   <= '0;
            i     <= '0;
            j     <= '0;
            state <= (nb == '0) ? S_IDLE : S_PAIR_NEXT;
          end else begin
            bin <= bin + pdh_pkg::NB_W'(1);
          end
        end
        S_PAIR_NEXT: begin
          if (all_done) begin
            state <= S_EMIT_READ;
          end else if (row_done) begin
            i <= i + pdh_pkg::PT_CW'(1);
            j <= '0;
          end else begin
            state <= S_PAIR_DIST;
          end
        end
        S_PAIR_DIST: begin
          step  <= pdh_pkg::STEP_W'(pdh_pkg::QUO_W - 1);
          state <= S_PAIR_DIV;
        end
        S_PAIR_DIV: begin
          if (step == '0) begin
            state <= S_HIST_READ;
          end else begin
            step <= step - pdh_pkg::STEP_W'(1);
          end
        end
        S_HIST_READ: state <= S_HIST_WRITE;
        S_HIST_WRITE: begin
          j     <= j + pdh_pkg::PT_CW'(1);
          state <= S_PAIR_NEXT;
        end
        S_EMIT_READ: state <= S_EMIT_LOAD;
        S_EMIT_LOAD: begin
          rsp_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            if (last_bin) begin
              state <= S_IDLE;
            end else begin
              bin   <= bin + pdh_pkg::NB_W'(1);
              state <= S_EMIT_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/pdh_datapath.sv -----
// datapath of the pair distance histogram unit: point stores, distance, bin divider, histogram
// depends on pdh_pkg; steered by pdh_ctrl through pdh_pkg::dp_cmd_t
module pdh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pdh_pkg::cfg_t       cfg,
  input  pdh_pkg::dp_cmd_t    cmd,
  output pdh_pkg::dp_status_t status,
  output pdh_pkg::rsp_t       rsp
);

  logic signed [pdh_pkg::COORD_W-1:0] set_a [pdh_pkg::MAX_POINTS];
  logic signed [pdh_pkg::COORD_W-1:0] set_b [pdh_pkg::MAX_POINTS];
  logic [pdh_pkg::COUNT_W-1:0]        hist  [pdh_pkg::NUM_BINS];

  logic [pdh_pkg::PT_CW-1:0]          count_a;
  logic [pdh_pkg::PT_CW-1:0]          count_b;
  logic signed [pdh_pkg::COORD_W-1:0] qa_i;
  logic signed [pdh_pkg::COORD_W-1:0] qa_j;
  logic signed [pdh_pkg::COORD_W-1:0] qb_j;
  logic [pdh_pkg::COORD_W-1:0]        rem;
  logic [pdh_pkg::QUO_W-1:0]          quo;
  logic                               is_near;
  logic                               hhit;
  logic [pdh_pkg::BIN_AW-1:0]         hbin;
  logic [pdh_pkg::COUNT_W-1:0]        cnt_rd;

  logic                               a_room;
  logic                               b_room;
  logic signed [pdh_pkg::COORD_W-1:0] q_pt;
  logic signed [pdh_pkg::COORD_W:0]   diff;
  logic [pdh_pkg::COORD_W:0]          mag;
  logic [pdh_pkg::COORD_W-1:0]        sep;
  logic [pdh_pkg::WIDTH_W-1:0]        width_eff;
  logic [pdh_pkg::DIV_W-1:0]          div_sub;
  logic                               div_ge;
  logic [pdh_pkg::NB_W-1:0]           nb;
  logic                               hit_calc;
  logic [pdh_pkg::BIN_AW-1:0]         bin_calc;
  logic [pdh_pkg::BIN_AW-1:0]         raddr;

  assign a_room = (count_a < pdh_pkg::PT_CW'(pdh_pkg::MAX_POINTS));
  assign b_room = (count_b < pdh_pkg::PT_CW'(pdh_pkg::MAX_POINTS));
  assign status = '{count_a: count_a, count_b: count_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.clear_sets) begin
      count_a <= '0;
      count_b <= '0;
    end else begin
      if (cmd.load_a && a_room) begin
        count_a <= count_a + pdh_pkg::PT_CW'(1);
      end
      if (cmd.load_b && b_room) begin
        count_b <= count_b + pdh_pkg::PT_CW'(1);
      end
    end
  end

  // point stores: one write port, set a has two read ports for auto pairs
  always_ff @(posedge clk) begin
    if (cmd.load_a && a_room) begin
      set_a[count_a[pdh_pkg::PT_AW-1:0]] <= cmd.point;
    end
    if (cmd.load_b && b_room) begin
      set_b[count_b[pdh_pkg::PT_AW-1:0]] <= cmd.point;
    end
    if (cmd.rd_pts) begin
      qa_i <= set_a[cmd.addr_i];
      qa_j <= set_a[cmd.addr_j];
      qb_j <= set_b[cmd.addr_j];
    end
  end

  assign q_pt = cfg.mode ? qb_j : qa_j;
  assign diff = {qa_i[pdh_pkg::COORD_W-1], qa_i} - {q_pt[pdh_pkg::COORD_W-1], q_pt};
  assign mag  = diff[pdh_pkg::COORD_W] ? (~diff + 1'b1) : diff;
  assign sep  = mag[pdh_pkg::COORD_W-1:0];

  // restoring division, one quotient bit per step; top bit flags a quotient past the bins
  assign width_eff = pdh_pkg::eff_width(cfg.bin_width);
  assign div_sub   = {pdh_pkg::QUO_W'(0), width_eff} << cmd.step;
  assign div_ge    = (pdh_pkg::DIV_W'(rem) >= div_sub);

  always_ff @(posedge clk) begin
    if (cmd.calc_dist) begin
      rem     <= sep;
      is_near <= (sep <= pdh_pkg::COORD_W'(cfg.small_distance));
      quo     <= '0;
    end else if (cmd.div_step && div_ge) begin
      rem           <= rem - div_sub[pdh_pkg::COORD_W-1:0];
      quo[cmd.step] <= 1'b1;
    end
  end

  assign nb       = pdh_pkg::eff_bins(cfg.bins_in_use);
  assign hit_calc = is_near || (!quo[pdh_pkg::QUO_W-1] && (quo[pdh_pkg::QUO_W-2:0] < nb));
  assign bin_calc = is_near ? '0 : quo[pdh_pkg::BIN_AW-1:0];
  assign raddr    = cmd.emit_sel ? cmd.bin_addr : bin_calc;

  always_ff @(posedge clk) begin
    cnt_rd <= hist[raddr];
    if (cmd.hist_clr) begin
      hist[cmd.bin_addr] <= '0;
    end else if (cmd.hist_inc && hhit && cnt_rd != pdh_pkg::COUNT_MAX) begin
      hist[hbin] <= cnt_rd + pdh_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_sample) begin
      hhit <= hit_calc;
      hbin <= bin_calc;
    end
    if (cmd.out_load) begin
      rsp <= '{bin_index: cmd.bin_addr, pair_count: cnt_rd, last: cmd.out_last};
    end
  end

endmodule

// ----- hdl/pair_distance_histogram_unit.sv -----
// Pair distance histogram unit. Point loads (kind 0 into set a, kind 1 into set b) and
// set clears (kind 3) are taken one per cycle and give no result; a load into a full set of
// 4096 points is dropped. A start (kind 2) clears the 64-bin histogram bin by bin, then
// walks every pair (j below i within set a in auto mode, all of a by b in cross mode),
// passing each separation through the shared 8-step restoring divider that turns it into
// a bin number. It then sends one result per bin in use, last marked on the final bin.
// A start with zero bins in use returns to idle after the clear with no result. New items
// are stalled from the start until the last bin has been taken. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while idle, as the
// block itself does not enforce this.
// depends on pdh_pkg, pdh_ctrl, pdh_datapath and the assertion macro header
`include "pair_distance_histogram_unit_assert.svh"

module pair_distance_histogram_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  pdh_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output pdh_pkg::rsp_t                     rsp,
  input  logic                              cfg_we,
  input  logic [pdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pdh_pkg::cfg_t       cfg;
  pdh_pkg::dp_cmd_t    cmd;
  pdh_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= 1'b0;
      cfg.bin_width      <= pdh_pkg::BIN_WIDTH_RST;
      cfg.small_distance <= pdh_pkg::SMALL_RST;
      cfg.bins_in_use    <= pdh_pkg::BINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdh_pkg::REG_MODE:      cfg.mode           <= cfg_data[0];
        pdh_pkg::REG_BIN_WIDTH: cfg.bin_width      <= cfg_data[pdh_pkg::WIDTH_W-1:0];
        pdh_pkg::REG_SMALL:     cfg.small_distance <= cfg_data[pdh_pkg::SMALL_W-1:0];
        pdh_pkg::REG_BINS:      cfg.bins_in_use    <= cfg_data[pdh_pkg::NB_W-1:0];
        default: ;
      endcase
    end
  end

  pdh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg       (cfg),
    .status    (status),
    .cmd       (cmd)
  );

  pdh_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // results only go out while new items are held off
  `PDH_ASSERT(a_emit_busy, !rsp_valid || req_stall)
  // an accepted start locks the input side on the next cycle
  `PDH_ASSERT_NEXT(a_start_locks, req_valid && !req_stall && req.kind == pdh_pkg::KIND_START, req_stall)
  // the clearing sweep and a count update never share the write port
  `PDH_ASSERT(a_hist_port, !(cmd.hist_clr && cmd.hist_inc))
  // fill counts never run past the store depth
  `PDH_ASSERT(a_count_a_bound, status.count_a <= pdh_pkg::PT_CW'(pdh_pkg::MAX_POINTS))
  `PDH_ASSERT(a_count_b_bound, status.count_b <= pdh_pkg::PT_CW'(pdh_pkg::MAX_POINTS))

endmodule

// ----- tb/tb.sv -----
// testbench for the pair distance histogram unit: a directed script and random load/start
// sequences, every bin item checked against a predictor held here or a fixed script result
// depends on pdh_pkg and pair_distance_histogram_unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdh_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RANDOM_ITEMS  = 460;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 500;
  localparam int END_PAUSE     = 200;
  localparam int CYCLE_LIMIT   = 20_000_000;
  localparam int SCRIPT_ROWS   = 31;

  localparam logic [1:0] KIND_LIST [4] = '{KIND_LOAD_A, KIND_LOAD_B, KIND_START, KIND_CLEAR};

  typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   rk;
    logic [1:0]  code;         // item kind or register index
    logic [31:0] value;        // coordinate or register data
    int          fixed_bins;   // -1: results come from the predictor
    int          fixed_first;  // count in bin 0, others zero
  } script_row_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic                      mode_now;
  logic [WIDTH_W-1:0]        width_now;
  logic [SMALL_W-1:0]        small_now;
  logic [NB_W-1:0]           bins_now;
  logic signed [COORD_W-1:0] points_a [$];
  logic signed [COORD_W-1:0] points_b [$];
  rsp_t                      pending_bins [$];

  int errors;
  int cycles;
  int items_sent;
  int items_sent_limit;
  int gap_pct;
  bit calm;
  bit busy;
  bit want_hold;

  script_row_t script [SCRIPT_ROWS];

  pair_distance_histogram_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void log_fault(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%s", what);
    end
  endfunction

  // histogram over the loaded sets with the current settings
  function automatic void count_separations();
    logic [COUNT_W-1:0] tally [NUM_BINS];
    longint unsigned    w;
    longint unsigned    gap;
    longint unsigned    slot;
    longint             p;
    longint             q;
    int                 nbins;
    int                 i;
    int                 j;
    int                 jn;
    rsp_t               item;
    w = (width_now == '0) ? 1 : width_now;
    nbins = (int'(bins_now) > NUM_BINS) ? NUM_BINS : int'(bins_now);
    if (nbins == 0) begin
      return;
    end
    for (i = 0; i < NUM_BINS; i++) begin
      tally[i] = '0;
    end
    for (i = 0; i < points_a.size(); i++) begin
      jn = mode_now ? points_b.size() : i;
      for (j = 0; j < jn; j++) begin
        p = points_a[i];
        q = mode_now ? points_b[j] : points_a[j];
        gap = (p >= q) ? p - q : q - p;
        slot = (gap <= small_now) ? 0 : gap / w;
        if (slot < nbins && tally[slot] != COUNT_MAX) begin
          tally[slot]++;
        end
      end
    end
    for (i = 0; i < nbins; i++) begin
      item.bin_index  = BIN_AW'(i);
      item.pair_count = tally[i];
      item.last       = (i == nbins - 1);
      pending_bins.insert(pending_bins.size(), item);
    end
  endfunction

  function automatic void take_item(input logic [1:0] kind, input logic [31:0] coord,
                                    input int fixed_bins, input int fixed_first);
    rsp_t item;
    int   i;
    case (kind)
      KIND_LOAD_A: begin
        if (points_a.size() < MAX_POINTS) points_a.insert(points_a.size(), coord);
      end
      KIND_LOAD_B: begin
        if (points_b.size() < MAX_POINTS) points_b.insert(points_b.size(), coord);
      end
      KIND_CLEAR: begin
        points_a.delete();
        points_b.delete();
      end
      KIND_START: begin
        if (fixed_bins < 0) begin
          count_separations();
        end else begin
          for (i = 0; i < fixed_bins; i++) begin
            item.bin_index  = BIN_AW'(i);
            item.pair_count = (i == 0) ? COUNT_W'(fixed_first) : '0;
            item.last       = (i == fixed_bins - 1);
            pending_bins.insert(pending_bins.size(), item);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // coordinates mostly within reach of the bins in use around base
  function automatic logic [31:0] pick_coord(input logic [31:0] base);
    longint unsigned span;
    longint unsigned r;
    int              nb;
    int              sel;
    nb = (bins_now == '0) ? 1 : ((int'(bins_now) > NUM_BINS) ? NUM_BINS : int'(bins_now));
    span = 64'((width_now == '0) ? 1 : width_now) * 64'(nb);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    r = {$urandom, $urandom};
    sel = $urandom_range(0, 19);
    if (sel < 13) return base + 32'(r % (span + 1));
    if (sel < 15) return base + $urandom_range(0, 2 * int'(small_now) + 2);
    if (sel < 18) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [31:0] coord,
                           input int fixed_bins, input int fixed_first);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req.kind       = kind;
    req.coordinate = coord;
    req_valid      = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    take_item(kind, coord, fixed_bins, fixed_first);
    items_sent++;
    busy = 1'b1;
    @(negedge clk);
  endtask

  // register writes only once the block has gone quiet
  task automatic settle();
    req_valid = 1'b0;
    if (busy) begin
      while (pending_bins.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      @(negedge clk);
      busy = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value, input bit noisy);
    logic [30:0] keep;
    logic [30:0] data;
    case (idx)
      REG_MODE:      keep = 31'h1;
      REG_BIN_WIDTH: keep = '1;
      REG_SMALL:     keep = 31'hFFFF;
      default:       keep = 31'h7F;
    endcase
    data = value & keep;
    // junk above the register width must be ignored
    if (noisy) data = data | (31'($urandom) & ~keep);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MODE:      mode_now  = data[0];
      REG_BIN_WIDTH: width_now = data;
      REG_SMALL:     small_now = data[SMALL_W-1:0];
      default:       bins_now  = data[NB_W-1:0];
    endcase
  endtask

  task automatic random_config();
    logic [30:0] w;
    logic [30:0] s;
    logic [30:0] b;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = 31'd1;
      2:       w = '1;
      3, 4:    w = 31'($urandom_range(1, 64));
      5, 6, 7: w = 31'($urandom_range(100, 5000));
      8:       w = 31'($urandom);
      default: w = 31'($urandom_range(5000, 1 << 20));
    endcase
    case ($urandom_range(0, 5))
      0:       s = '0;
      1:       s = 31'hFFFF;
      2:       s = 31'($urandom_range(0, 65535));
      default: s = 31'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 19))
      0:       b = '0;
      1, 2:    b = 31'd1;
      3, 4, 5: b = 31'd64;
      6, 7:    b = 31'($urandom_range(65, 127));
      default: b = 31'($urandom_range(1, 64));
    endcase
    write_reg(REG_MODE, 31'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    write_reg(REG_BIN_WIDTH, w, 1'b0);
    write_reg(REG_SMALL, s, $urandom_range(0, 3) == 0);
    write_reg(REG_BINS, b, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_sequence(input bit press);
    logic [31:0] base;
    int          na;
    int          nb;
    int          k;
    bit          big;
    calm = (items_sent >= items_sent_limit - CALM_ITEMS);
    if (points_a.size() > 24 || points_b.size() > 24 || $urandom_range(0, 9) < 7) begin
      send_item(KIND_CLEAR, $urandom, -1, 0);
    end
    big = ($urandom_range(0, 9) == 0);
    na = big ? $urandom_range(12, 24) : $urandom_range(0, 8);
    nb = 0;
    if (mode_now || $urandom_range(0, 3) == 0) begin
      nb = big ? $urandom_range(12, 24) : $urandom_range(0, 8);
    end
    base = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    while (na + nb > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_LIST[$urandom_range(0, 3)], $urandom, -1, 0);
      end else if ($urandom_range(1, na + nb) <= na) begin
        send_item(KIND_LOAD_A, pick_coord(base), -1, 0);
        na--;
      end else begin
        send_item(KIND_LOAD_B, pick_coord(base), -1, 0);
        nb--;
      end
    end
    if (press && !calm) want_hold = 1'b1;
    send_item(KIND_START, $urandom, -1, 0);
    // keep offering items while the receiver holds off
    if (press && !calm) begin
      for (k = 0; k < 3; k++) send_item(KIND_LOAD_A, pick_coord(base), -1, 0);
    end
  endtask

  initial begin : main
    int r;
    int phase;
    int nseq;
    int k;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    items_sent = 0;
    items_sent_limit = 0;
    gap_pct   = 20;
    calm      = 1'b0;
    busy      = 1'b0;
    want_hold = 1'b0;
    mode_now  = 1'b0;
    width_now = BIN_WIDTH_RST;
    small_now = SMALL_RST;
    bins_now  = BINS_RST;

    script = '{
      '{ROW_ITEM, KIND_START,    32'h0,         50,  0},  // empty set after reset
      '{ROW_ITEM, KIND_LOAD_A,   32'h0,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_A,   32'h5,         -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         50,  1},  // one pair under the small distance
      '{ROW_ITEM, KIND_LOAD_A,   32'h8000_0000, -1,  0},
      '{ROW_ITEM, KIND_LOAD_A,   32'h7FFF_FFFF, -1,  0},
      '{ROW_ITEM, KIND_START,    32'hFFFF_FFFF, -1,  0},
      '{ROW_REG,  REG_BIN_WIDTH, 32'h7FFF_FFFF, -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0},
      '{ROW_REG,  REG_SMALL,     32'hFFFF,      -1,  0},
      '{ROW_REG,  REG_BINS,      32'h7F,        -1,  0},  // saturates to all bins
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0},
      '{ROW_REG,  REG_BIN_WIDTH, 32'h0,         -1,  0},  // zero width counts as one
      '{ROW_REG,  REG_SMALL,     32'h0,         -1,  0},
      '{ROW_REG,  REG_BINS,      32'd64,        -1,  0},
      '{ROW_ITEM, KIND_CLEAR,    32'h0,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_A,   32'h0,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_A,   32'h1,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_A,   32'd63,        -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0},
      '{ROW_REG,  REG_MODE,      32'h1,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_B,   32'h2,         -1,  0},
      '{ROW_ITEM, KIND_LOAD_B,   32'hFFFF_FFFF, -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0},
      '{ROW_REG,  REG_BINS,      32'h0,         -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,          0,  0},  // no bins, no result
      '{ROW_ITEM, KIND_LOAD_B,   32'h40,        -1,  0},
      '{ROW_REG,  REG_BINS,      32'h1,         -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0},
      '{ROW_ITEM, KIND_CLEAR,    32'h0,         -1,  0},
      '{ROW_ITEM, KIND_START,    32'h0,         -1,  0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].rk == ROW_REG) begin
        settle();
        write_reg(script[r].code, script[r].value[30:0], 1'b0);
      end else begin
        send_item(script[r].code, script[r].value, script[r].fixed_bins,
                  script[r].fixed_first);
      end
    end

    items_sent_limit = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < items_sent_limit) begin
      settle();
      random_config();
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      nseq = $urandom_range(1, 3);
      for (k = 0; k < nseq; k++) begin
        run_sequence(k == 0 && phase % 8 == 2);
      end
      phase++;
    end

    req_valid = 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    int window;
    int pct;
    rsp_stall = 1'b0;
    window = 0;
    pct = 0;
    forever begin
      @(negedge clk);
      if (want_hold && !calm && pending_bins.size() != 0) begin
        // long hold so the block backs up
        want_hold = 1'b0;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall = 1'b0;
      end else begin
        if (window == 0) begin
          window = $urandom_range(40, 200);
          case ($urandom_range(0, 2))
            0:       pct = 0;
            1:       pct = 10;
            default: pct = 35;
          endcase
        end
        window--;
        if (!calm && $urandom_range(0, 99) < pct) begin
          rsp_stall = 1'b1;
          repeat ($urandom_range(1, 5)) @(negedge clk);
          rsp_stall = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_bins
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_bins.size() == 0) begin
        log_fault($sformatf("unexpected bin item: bin %0d count %0d last %0b",
                            rsp.bin_index, rsp.pair_count, rsp.last));
      end else begin
        want = pending_bins.pop_front();
        if (rsp.bin_index !== want.bin_index || rsp.pair_count !== want.pair_count ||
            rsp.last !== want.last) begin
          log_fault($sformatf(
            "bin item mismatch: expected bin %0d count %0d last %0b, got bin %0d count %0d last %0b",
            want.bin_index, want.pair_count, want.last,
            rsp.bin_index, rsp.pair_count, rsp.last));
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule
